// ----- hw/rtl/tbgd_pkg.sv -----
// Shared types and constants for the two-beam goal detector.
package tbgd_pkg;

    localparam int STAMP_W     = 32;
    localparam int LIMIT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF = 2'd1;

    localparam logic [LIMIT_W-1:0] WINDOW_RESET  = 16'd500;
    localparam logic [LIMIT_W-1:0] HOLDOFF_RESET = 16'd1000;

    // One logged edge: which beam, which direction and when.
    typedef struct packed {
        logic               beam_two;
        logic               rise;
        logic [STAMP_W-1:0] stamp_ms;
    } log_entry_t;

    // Commands from the sequencer to the edge log.
    typedef struct packed {
        logic       wr_en;
        logic       clear;
        log_entry_t entry;
    } log_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_ONE,
        ST_LOG_TWO,
        ST_SCAN,
        ST_GAP_RR,
        ST_GAP_FR,
        ST_GAP_RF,
        ST_HOLD,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        GAP_SEL_RR,
        GAP_SEL_FR,
        GAP_SEL_RF,
        GAP_SEL_HOLD
    } gap_sel_t;

endpackage

// ----- hw/rtl/tbgd_channels.sv -----
// Handshake channels for beam samples and detection results.
interface tbgd_sample_if;
    logic                         valid;
    logic                         ready;
    logic                         beam_one;
    logic                         beam_two;
    logic [tbgd_pkg::STAMP_W-1:0] now_ms;

    modport source (output valid, output beam_one, output beam_two, output now_ms,
                    input ready);
    modport sink (input valid, input beam_one, input beam_two, input now_ms,
                  output ready);
endinterface

interface tbgd_result_if;
    logic valid;
    logic ready;
    logic goal;
    logic crossing_matched;
    logic edge_seen;

    modport source (output valid, output goal, output crossing_matched,
                    output edge_seen, input ready);
    modport sink (input valid, input goal, input crossing_matched,
                  input edge_seen, output ready);
endinterface

// ----- hw/rtl/tbgd_gap_unit.sv -----
// Shared signed-gap subtractor with the window and holdoff compares.
module tbgd_gap_unit (
    input  logic [tbgd_pkg::STAMP_W-1:0] later_ms,
    input  logic [tbgd_pkg::STAMP_W-1:0] earlier_ms,
    input  logic [tbgd_pkg::LIMIT_W-1:0] limit_ms,
    output logic                         below,
    output logic                         beyond
);
    import tbgd_pkg::*;

    logic [STAMP_W-1:0] diff;
    logic [STAMP_W-1:0] limit_ext;

    assign diff      = later_ms - earlier_ms;
    assign limit_ext = {{(STAMP_W-LIMIT_W){1'b0}}, limit_ms};

    // A negative gap is always inside the window and never past the holdoff.
    assign below  = diff[STAMP_W-1] | (diff < limit_ext);
    assign beyond = ~diff[STAMP_W-1] & (diff > limit_ext);
endmodule

// ----- hw/rtl/tbgd_edge_log.sv -----
// Ring of logged beam edges with per-entry valid bits.
module tbgd_edge_log #(
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbgd_pkg::log_cmd_t       cmd,
    input  logic [$clog2(DEPTH)-1:0] rd_ptr,
    output logic                     rd_valid,
    output tbgd_pkg::log_entry_t     rd_entry,
    output logic [$clog2(DEPTH)-1:0] slot
);
    import tbgd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0] slot_reg, slot_next;
    log_entry_t       entry_reg [DEPTH];

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (cmd.clear)
        begin
            valid_next = '0;
            slot_next  = '0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[slot_reg] = 1'b1;
            slot_next = (slot_reg == LAST) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.clear)
        begin
            entry_reg[slot_reg] <= cmd.entry;
        end
    end

    assign rd_valid = valid_reg[rd_ptr];
    assign rd_entry = entry_reg[rd_ptr];
    assign slot     = slot_reg;
endmodule

// ----- hw/rtl/two_beam_goal_detector.sv -----
// Top level of the two-beam goal detector: sequencer, scan and result register.
//
// Usage: each item on the samples channel is one reading of the two beam
// detectors (beam_one, beam_two) with its millisecond timestamp now_ms.
// Every accepted item yields exactly one item on the results channel with
// goal, crossing_matched and edge_seen. Both channels use valid/ready; an
// item moves on a rising edge where both are high.
// Sequence: a sample with no level change passes through ST_LOG_ONE,
// ST_LOG_TWO and ST_FINISH before the block is ready again; a sample with an
// edge also runs a scan of the edge log, one entry per cycle, and the single
// gap subtractor, which evaluates the three crossing gaps and the holdoff
// test one after another. In ST_FINISH the result goes into the output
// register once that register is free, and from there onto the results channel.
// The result sits in an output register, so the next sample is accepted
// while an earlier result still waits; if the receiver keeps stalling, the
// block holds its next finished result until the register frees up.
// Configuration writes (window_ms, goal_holdoff_ms) take effect at once and
// are meant to happen only while the block is idle. Reset clears the edge
// log, the previous levels and the last match time, and restores the
// register defaults of 500 ms and 1000 ms.
module two_beam_goal_detector #(
    parameter int LOG_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tbgd_sample_if.sink                      samples,
    tbgd_result_if.source                    results,
    input  logic                             cfg_we,
    input  logic [tbgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tbgd_pkg::*;

    localparam int PTR_W = $clog2(LOG_DEPTH);
    localparam logic [PTR_W-1:0] SCAN_LAST = PTR_W'(LOG_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(LOG_DEPTH);

    // Sequencer state.
    state_t state_reg, state_next;

    // Captured sample.
    logic               b1_reg, b2_reg;
    logic [STAMP_W-1:0] now_reg;

    // Block state kept across items.
    logic [1:0]         prev_levels_reg, prev_levels_next;
    logic [STAMP_W-1:0] last_match_reg, last_match_next;
    logic [LIMIT_W-1:0] window_reg, window_next;
    logic [LIMIT_W-1:0] holdoff_reg, holdoff_next;

    // Working registers of one item.
    logic               edge_reg, edge_next;
    logic               ok_reg, ok_next;
    logic               hold_ok_reg, hold_ok_next;
    logic [STAMP_W-1:0] r1_reg, r1_next;
    logic [STAMP_W-1:0] f1_reg, f1_next;
    logic [STAMP_W-1:0] r2_reg, r2_next;
    logic [PTR_W-1:0]   scan_cnt_reg, scan_cnt_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic out_goal_reg, out_goal_next;
    logic out_match_reg, out_match_next;
    logic out_edge_reg, out_edge_next;

    // Control decoded from the state.
    logic       take_sample;
    logic       load_out;
    logic       out_free;
    logic       match_now;
    gap_sel_t   gap_sel;
    log_cmd_t   log_cmd;

    // Edge log and shared gap unit connections.
    logic [PTR_W-1:0]   slot;
    logic [PTR_W:0]     rd_sum;
    logic [PTR_W-1:0]   rd_ptr;
    logic               rd_valid;
    log_entry_t         rd_entry;
    logic [STAMP_W-1:0] gap_later, gap_earlier;
    logic [LIMIT_W-1:0] gap_limit;
    logic               gap_below, gap_beyond;

    logic edge_one, edge_two;

    assign edge_one  = b1_reg ^ prev_levels_reg[0];
    assign edge_two  = b2_reg ^ prev_levels_reg[1];
    assign out_free  = !out_valid_reg || results.ready;
    assign match_now = edge_reg && ok_reg;

    tbgd_edge_log #(
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (log_cmd),
        .rd_ptr   (rd_ptr),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .slot     (slot)
    );

    // The scan starts at the write slot, the oldest entry once the log has wrapped; unwritten slots are invalid.
    assign rd_sum = {1'b0, slot} + {1'b0, scan_cnt_reg};
    assign rd_ptr = (rd_sum >= DEPTH_EXT) ? PTR_W'(rd_sum - DEPTH_EXT) : rd_sum[PTR_W-1:0];

    tbgd_gap_unit u_gap (
        .later_ms   (gap_later),
        .earlier_ms (gap_earlier),
        .limit_ms   (gap_limit),
        .below      (gap_below),
        .beyond     (gap_beyond)
    );

    // Operand selection for the one subtractor.
    always_comb
    begin
        case (gap_sel)
            GAP_SEL_RR:
            begin
                gap_later   = r2_reg;
                gap_earlier = r1_reg;
                gap_limit   = window_reg;
            end
            GAP_SEL_FR:
            begin
                gap_later   = f1_reg;
                gap_earlier = r1_reg;
                gap_limit   = window_reg;
            end
            GAP_SEL_RF:
            begin
                gap_later   = r2_reg;
                gap_earlier = f1_reg;
                gap_limit   = window_reg;
            end
            GAP_SEL_HOLD:
            begin
                gap_later   = now_reg;
                gap_earlier = last_match_reg;
                gap_limit   = holdoff_reg;
            end
            default:
            begin
                gap_later   = r2_reg;
                gap_earlier = r1_reg;
                gap_limit   = window_reg;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = ST_LOG_ONE;
                end
            end
            ST_LOG_ONE:
            begin
                state_next = ST_LOG_TWO;
            end
            ST_LOG_TWO:
            begin
                state_next = (edge_one || edge_two) ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next = ST_GAP_RR;
                end
            end
            ST_GAP_RR:
            begin
                state_next = ST_GAP_FR;
            end
            ST_GAP_FR:
            begin
                state_next = ST_GAP_RF;
            end
            ST_GAP_RF:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb
    begin
        take_sample          = 1'b0;
        load_out             = 1'b0;
        gap_sel              = GAP_SEL_RR;
        log_cmd.wr_en        = 1'b0;
        log_cmd.clear        = 1'b0;
        log_cmd.entry.beam_two = 1'b0;
        log_cmd.entry.rise   = b1_reg;
        log_cmd.entry.stamp_ms = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                take_sample = 1'b1;
            end
            ST_LOG_ONE:
            begin
                log_cmd.wr_en = edge_one;
            end
            ST_LOG_TWO:
            begin
                log_cmd.wr_en          = edge_two;
                log_cmd.entry.beam_two = 1'b1;
                log_cmd.entry.rise     = b2_reg;
            end
            ST_GAP_RR:
            begin
                gap_sel = GAP_SEL_RR;
            end
            ST_GAP_FR:
            begin
                gap_sel = GAP_SEL_FR;
            end
            ST_GAP_RF:
            begin
                gap_sel = GAP_SEL_RF;
            end
            ST_HOLD:
            begin
                gap_sel = GAP_SEL_HOLD;
            end
            ST_FINISH:
            begin
                load_out      = out_free;
                log_cmd.clear = out_free && match_now;
            end
            default:
            begin
                take_sample = 1'b0;
            end
        endcase
    end

    assign samples.ready = take_sample;

    // Datapath next values.
    always_comb
    begin
        prev_levels_next = prev_levels_reg;
        last_match_next  = last_match_reg;
        window_next      = window_reg;
        holdoff_next     = holdoff_reg;
        edge_next        = edge_reg;
        ok_next          = ok_reg;
        hold_ok_next     = hold_ok_reg;
        r1_next          = r1_reg;
        f1_next          = f1_reg;
        r2_next          = r2_reg;
        scan_cnt_next    = scan_cnt_reg;
        out_valid_next   = out_valid_reg;
        out_goal_next    = out_goal_reg;
        out_match_next   = out_match_reg;
        out_edge_next    = out_edge_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:  window_next  = cfg_data;
                CFG_HOLDOFF: holdoff_next = cfg_data;
                default:     window_next  = window_reg;
            endcase
        end

        case (state_reg)
            ST_LOG_TWO:
            begin
                edge_next     = edge_one || edge_two;
                ok_next       = 1'b1;
                hold_ok_next  = 1'b0;
                r1_next       = '0;
                f1_next       = '0;
                r2_next       = '0;
                scan_cnt_next = '0;
                if (edge_one || edge_two)
                begin
                    prev_levels_next = {b2_reg, b1_reg};
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (rd_valid)
                begin
                    if (!rd_entry.beam_two)
                    begin
                        if (rd_entry.rise)
                        begin
                            r1_next = rd_entry.stamp_ms;
                        end
                        else
                        begin
                            f1_next = rd_entry.stamp_ms;
                        end
                    end
                    else if (rd_entry.rise)
                    begin
                        r2_next = rd_entry.stamp_ms;
                    end
                end
            end
            ST_GAP_RR, ST_GAP_FR, ST_GAP_RF:
            begin
                ok_next = ok_reg && gap_below;
            end
            ST_HOLD:
            begin
                hold_ok_next = gap_beyond;
            end
            default:
            begin
                scan_cnt_next = scan_cnt_reg;
            end
        endcase

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_goal_next  = match_now && hold_ok_reg;
            out_match_next = match_now;
            out_edge_next  = edge_reg;
            if (match_now)
            begin
                last_match_next = now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_levels_reg <= '0;
            last_match_reg  <= '0;
            window_reg      <= WINDOW_RESET;
            holdoff_reg     <= HOLDOFF_RESET;
            scan_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_levels_reg <= prev_levels_next;
            last_match_reg  <= last_match_next;
            window_reg      <= window_next;
            holdoff_reg     <= holdoff_next;
            scan_cnt_reg    <= scan_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (samples.valid && take_sample)
        begin
            b1_reg  <= samples.beam_one;
            b2_reg  <= samples.beam_two;
            now_reg <= samples.now_ms;
        end
        edge_reg      <= edge_next;
        ok_reg        <= ok_next;
        hold_ok_reg   <= hold_ok_next;
        r1_reg        <= r1_next;
        f1_reg        <= f1_next;
        r2_reg        <= r2_next;
        out_goal_reg  <= out_goal_next;
        out_match_reg <= out_match_next;
        out_edge_reg  <= out_edge_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.goal             = out_goal_reg;
    assign results.crossing_matched = out_match_reg;
    assign results.edge_seen        = out_edge_reg;

    // A goal is only ever reported together with a matched crossing, and a
    // match only on a sample that had an edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.goal || results.crossing_matched))
    else $error("goal reported without a matched crossing");

    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.crossing_matched || results.edge_seen))
    else $error("crossing matched on a sample without an edge");

    // A matched crossing records its time and empties the log.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && match_now) |=> (last_match_reg == $past(now_reg)) && (slot == '0))
    else $error("match did not record its time or reset the log");

    // The scan visits every log entry exactly once, then hands over to the gap checks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_cnt_reg == SCAN_LAST) |=> (state_reg == ST_GAP_RR))
    else $error("scan did not hand over to the gap checks");
endmodule

// ----- dv/tbgd_checker.sv -----
`timescale 1ns / 100ps
// Checker for the two-beam goal detector: predicts every result item and compares it.
module tbgd_checker #(
    parameter int LOG_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tbgd_sample_if                           samples,
    tbgd_result_if                           results,
    input  logic                             cfg_we,
    input  logic [tbgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               outstanding,
    output int                               failures
);
    import tbgd_pkg::*;

    typedef struct packed {
        logic goal;
        logic crossing_matched;
        logic edge_seen;
    } verdict_t;

    // Bit 0 holds the last level of beam one, bit 1 that of beam two.
    logic [1:0]         levels_seen;
    logic               log_valid [LOG_DEPTH];
    log_entry_t         log_slot  [LOG_DEPTH];
    int unsigned        write_slot;
    logic [STAMP_W-1:0] last_match_ms;
    logic [LIMIT_W-1:0] window_ms;
    logic [LIMIT_W-1:0] holdoff_ms;
    verdict_t           verdict_q [$];

    function automatic void log_edge(logic on_two, logic rise_dir, logic [STAMP_W-1:0] stamp);
        log_valid[write_slot] = 1'b1;
        log_slot[write_slot]  = '{beam_two: on_two, rise: rise_dir, stamp_ms: stamp};
        write_slot = (write_slot + 1) % LOG_DEPTH;
    endfunction

    // A gap that wraps negative always fits, whatever the window.
    function automatic logic fits_window(logic [STAMP_W-1:0] later, logic [STAMP_W-1:0] earlier);
        logic [STAMP_W-1:0] gap;
        gap = later - earlier;
        return gap[STAMP_W-1] || (gap < window_ms);
    endfunction

    function automatic verdict_t judge_sample(logic b1, logic b2, logic [STAMP_W-1:0] stamp);
        verdict_t           v;
        logic [STAMP_W-1:0] rise_one;
        logic [STAMP_W-1:0] fall_one;
        logic [STAMP_W-1:0] rise_two;
        logic [STAMP_W-1:0] since;
        int unsigned        k;
        int                 i;
        v        = '0;
        rise_one = '0;
        fall_one = '0;
        rise_two = '0;
        if (b1 != levels_seen[0])
        begin
            v.edge_seen = 1'b1;
            log_edge(1'b0, b1, stamp);
        end
        if (b2 != levels_seen[1])
        begin
            v.edge_seen = 1'b1;
            log_edge(1'b1, b2, stamp);
        end
        if (v.edge_seen)
        begin
            levels_seen = {b2, b1};
            // Oldest entry first, so the newest of each kind wins.
            for (i = 0; i < LOG_DEPTH; i++)
            begin
                k = (write_slot + i) % LOG_DEPTH;
                if (log_valid[k])
                begin
                    if (!log_slot[k].beam_two)
                    begin
                        if (log_slot[k].rise)
                            rise_one = log_slot[k].stamp_ms;
                        else
                            fall_one = log_slot[k].stamp_ms;
                    end
                    else if (log_slot[k].rise)
                        rise_two = log_slot[k].stamp_ms;
                end
            end
            v.crossing_matched = fits_window(rise_two, rise_one)
                              && fits_window(fall_one, rise_one)
                              && fits_window(rise_two, fall_one);
            if (v.crossing_matched)
            begin
                since = stamp - last_match_ms;
                foreach (log_valid[j])
                    log_valid[j] = 1'b0;
                write_slot    = 0;
                last_match_ms = stamp;
                v.goal        = !since[STAMP_W-1] && (since > holdoff_ms);
            end
        end
        return v;
    endfunction

    function automatic void check_field(string field, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %b, got %b", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            failures      = 0;
            levels_seen   = '0;
            write_slot    = 0;
            last_match_ms = '0;
            window_ms     = WINDOW_RESET;
            holdoff_ms    = HOLDOFF_RESET;
            foreach (log_valid[j])
                log_valid[j] = 1'b0;
            verdict_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW:  window_ms  = cfg_data;
                    CFG_HOLDOFF: holdoff_ms = cfg_data;
                    default: ;
                endcase
            end
            if (results.valid && results.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result item with nothing predicted: goal %b matched %b edge %b",
                           results.goal, results.crossing_matched, results.edge_seen);
                    failures++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("goal", want.goal, results.goal);
                    check_field("crossing_matched", want.crossing_matched,
                                results.crossing_matched);
                    check_field("edge_seen", want.edge_seen, results.edge_seen);
                end
            end
            if (samples.valid && samples.ready)
                verdict_q.push_back(judge_sample(samples.beam_one, samples.beam_two,
                                                 samples.now_ms));
            outstanding <= verdict_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the two-beam goal detector testbench: clock, reset, stimulus and verdict.
module tb;
    import tbgd_pkg::*;

    localparam int LOG_DEPTH     = 4;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int SEGMENTS      = 6;
    // Settling time at the end of the run; it is ample for the tail after the
    // last result.
    localparam int SETTLE_CYCLES = 2 * (8 + LOG_DEPTH);
    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;

    // The index field is two bits wide; these two indexes name no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     outstanding;
    int                     failures;

    tbgd_sample_if samples ();
    tbgd_result_if results ();

    // Idle percentages of the sample sender and of the result receiver.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // What the detector has last been shown, so that crossings are built on
    // top of the current beam levels and timestamps move forward from here.
    logic               level_one;
    logic               level_two;
    logic [STAMP_W-1:0] clock_ms;
    logic [LIMIT_W-1:0] window_now;
    logic [LIMIT_W-1:0] holdoff_now;
    logic               parked;
    int unsigned        sent_items;
    int unsigned        quiet_cycles;

    two_beam_goal_detector #(
        .LOG_DEPTH(LOG_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .results  (results),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tbgd_checker #(
        .LOG_DEPTH(LOG_DEPTH)
    ) crossing_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .results    (results),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .outstanding(outstanding),
        .failures   (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver decides afresh every cycle whether it stalls.
    always @(posedge clk)
        results.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drops valid unless it is already low, so that valid never gets two
    // assignments in one time step.
    task automatic park();
        if (!parked)
        begin
            samples.valid <= 1'b0;
            parked = 1'b1;
        end
    endtask

    // Offers one sample item, after a random idle stretch, and returns at the
    // edge where it is accepted. Valid stays high so the next item can follow
    // back to back.
    task automatic send_sample(input logic b1, input logic b2, input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            park();
            @(posedge clk);
        end
        samples.valid    <= 1'b1;
        samples.beam_one <= b1;
        samples.beam_two <= b2;
        samples.now_ms   <= stamp;
        parked = 1'b0;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        level_one  = b1;
        level_two  = b2;
        clock_ms   = stamp;
        sent_items++;
    endtask

    // Stops the sender and waits until every predicted result has come back.
    // The first edge is taken before the count is read, since the item
    // accepted at the current edge is not yet in it.
    task automatic drain();
        park();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // One register write; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == CFG_WINDOW)
            window_now = value;
        else if (index == CFG_HOLDOFF)
            holdoff_now = value;
    endtask

    // Time between edges of one crossing: mostly well inside the window,
    // now and then past it so that the window test fails too.
    function automatic int unsigned step_gap();
        int unsigned span;
        span = (window_now == 0) ? 20 : window_now;
        if ($urandom_range(7) == 0)
            return $urandom_range(2 * span, span);
        return $urandom_range(span / 2);
    endfunction

    // One crossing: beam one rises first, then one of several orders of the
    // remaining edges, with samples that change nothing now and then in between.
    // Levels are written {beam two, beam one}.
    task automatic crossing_burst();
        logic [1:0]  path [3];
        int unsigned span;
        int          i;
        span = (window_now == 0) ? 20 : window_now;
        case ($urandom_range(3))
            0:       path = '{2'b00, 2'b10, 2'b00};   // fall one, rise two, fall two
            1:       path = '{2'b11, 2'b10, 2'b00};   // rise two while beam one is active
            2:       path = '{2'b10, 2'b00, 2'b00};   // fall one and rise two together
            default: path = '{2'b11, 2'b01, 2'b00};   // beam two clears before beam one
        endcase
        if (level_one || level_two)
            send_sample(1'b0, 1'b0, clock_ms + step_gap());
        // The pause before the crossing straddles the holdoff, so goals and
        // matches inside the holdoff both turn up.
        send_sample(1'b1, 1'b0, clock_ms + $urandom_range(holdoff_now + 2 * span));
        for (i = 0; i < 3; i++)
        begin
            if ($urandom_range(3) == 0)
                send_sample(level_one, level_two, clock_ms + step_gap());
            send_sample(path[i][0], path[i][1], clock_ms + step_gap());
        end
    endtask

    // Random levels; sometimes the timestamp jumps anywhere, which also makes
    // gaps and the time since the last match wrap negative.
    task automatic noise_burst();
        repeat ($urandom_range(4, 1))
        begin
            if ($urandom_range(7) == 0)
                send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
            else
                send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                            clock_ms + $urandom_range(3000));
        end
    endtask

    initial
    begin
        int unsigned seg;
        int unsigned random_base;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_WINDOW;
        cfg_data         <= '0;
        samples.valid    <= 1'b0;
        samples.beam_one <= 1'b0;
        samples.beam_two <= 1'b0;
        samples.now_ms   <= '0;
        parked        = 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 52;
        level_one     = 1'b0;
        level_two     = 1'b0;
        clock_ms      = '0;
        window_now    = WINDOW_RESET;
        holdoff_now   = HOLDOFF_RESET;
        sent_items    = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset values: window 500 ms,
        // holdoff 1000 ms, last match at time zero.
        // Samples without any level change, at both ends of the timestamp range.
        send_sample(1'b0, 1'b0, 32'h0000_0000);
        send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
        // A lone beam-one rise matches against the empty kinds; it lands
        // exactly on the holdoff, so no goal.
        send_sample(1'b1, 1'b0, 32'd1000);
        send_sample(1'b0, 1'b0, 32'd1040);
        send_sample(1'b0, 1'b1, 32'd1060);
        // A beam-two fall is logged but the scan skips it.
        send_sample(1'b0, 1'b0, 32'd1100);
        // Late beam-one rise: both older gaps go negative, so this matches
        // with the holdoff long past and scores a goal.
        send_sample(1'b1, 1'b0, 32'd5000);
        send_sample(1'b1, 1'b1, 32'd5100);
        // Both beams change within one sample, falling and then rising; the
        // second pair overwrites the oldest log entry.
        send_sample(1'b0, 1'b0, 32'd5150);
        send_sample(1'b1, 1'b1, 32'd5200);

        // Window of zero: only negative gaps fit. Holdoff of zero.
        drain();
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_HOLDOFF, 16'd0);
        send_sample(1'b0, 1'b0, 32'd6000);
        send_sample(1'b1, 1'b0, 32'd6001);
        send_sample(1'b0, 1'b0, 32'hFFFF_FFF0);

        // Widest window and longest holdoff, across the timestamp wrap: the
        // time since the last match is negative first, then small.
        drain();
        write_reg(CFG_WINDOW, 16'hFFFF);
        write_reg(CFG_HOLDOFF, 16'hFFFF);
        send_sample(1'b1, 1'b0, 32'hFFFF_FFF8);
        send_sample(1'b0, 1'b0, 32'h0000_0004);
        send_sample(1'b0, 1'b1, 32'h0001_0005);

        // Writes to indexes that name no register must change nothing.
        drain();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_sample(1'b0, 1'b0, 32'h0001_0100);
        send_sample(1'b1, 1'b0, 32'h0001_0101);

        // Random part in segments, each with its own register setting. The
        // first two segments use the first idle mix, the next two the swapped
        // one, the last two have no idling at all.
        random_base = sent_items;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            send_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 52 : 0;
            recv_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 37 : 0;
            case (seg)
                0:
                begin
                    write_reg(CFG_WINDOW, 16'd200);
                    write_reg(CFG_HOLDOFF, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_WINDOW, 16'hFFFF);
                    write_reg(CFG_HOLDOFF, 16'hFFFF);
                end
                2:
                begin
                    write_reg(CFG_WINDOW, 16'd1);
                    write_reg(CFG_HOLDOFF, 16'd300);
                end
                3:
                begin
                    write_reg(CFG_WINDOW, 16'd0);
                    write_reg(CFG_HOLDOFF, 16'd1000);
                end
                4:
                begin
                    write_reg(CFG_WINDOW, 16'($urandom_range(1000, 20)));
                    write_reg(CFG_HOLDOFF, 16'($urandom_range(3000)));
                end
                default:
                begin
                    write_reg(CFG_SPARE_HI, 16'($urandom()));
                    write_reg(CFG_WINDOW, WINDOW_RESET);
                    write_reg(CFG_HOLDOFF, HOLDOFF_RESET);
                end
            endcase
            while (sent_items - random_base < (seg + 1) * RANDOM_ITEMS / SEGMENTS)
            begin
                // Now and then the sender holds back until the block has
                // handed over every result it owes.
                if ($urandom_range(19) == 0)
                    drain();
                if ($urandom_range(3) != 0)
                    crossing_burst();
                else
                    noise_burst();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
